// ===== src/lrt_pkg.sv =====
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared types and codes for the LRU replacement tracker.
// ----------------------------------------------------------------------------
package lrt_pkg;

    localparam int FRAME_W = 6;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        OP_VICTIM = 2'd0,
        OP_PIN    = 2'd1,
        OP_UNPIN  = 2'd2
    } op_t;

    typedef struct packed {
        logic [FRAME_W-1:0] victim_frame;
        logic               found;
        logic [COUNT_W-1:0] count;
    } res_t;

endpackage

// ===== src/lrt_link_ram.sv =====
// ----------------------------------------------------------------------------
// lrt_link_ram
// One-write, one-read link store with a registered read port.
// ----------------------------------------------------------------------------
module lrt_link_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lrt_list_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrt_list_ctrl
// List sequencer: issues the link read on accept, then unlinks or appends
// the frame and writes the changed links back in the following cycle.
// ----------------------------------------------------------------------------
module lrt_list_ctrl
    import lrt_pkg::*;
#(
    parameter int NUM_FRAMES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    func,
    input  logic [FRAME_W-1:0]            frame,
    input  logic                          out_busy,
    output logic [$clog2(NUM_FRAMES)-1:0] raddr,
    input  logic [$clog2(NUM_FRAMES)-1:0] next_rdata,
    input  logic [$clog2(NUM_FRAMES)-1:0] prev_rdata,
    output logic                          next_we,
    output logic [$clog2(NUM_FRAMES)-1:0] next_waddr,
    output logic [$clog2(NUM_FRAMES)-1:0] next_wdata,
    output logic                          prev_we,
    output logic [$clog2(NUM_FRAMES)-1:0] prev_waddr,
    output logic [$clog2(NUM_FRAMES)-1:0] prev_wdata,
    output logic                          res_load,
    output res_t                          res
);

    localparam int IW  = $clog2(NUM_FRAMES);
    // only frame numbers the port can carry can ever become members
    localparam int MW  = (NUM_FRAMES < (1 << FRAME_W)) ? NUM_FRAMES : (1 << FRAME_W);
    localparam int MIW = $clog2(MW);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    op_t                op_reg;
    logic [IW-1:0]      frm_reg;
    logic               frm_ok_reg;
    logic               hit_reg;
    logic [IW-1:0]      oldest_reg, oldest_next;
    logic [IW-1:0]      newest_reg, newest_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [MW-1:0]      member_reg, member_next;

    logic               accept;
    logic               in_frame_ok;
    logic               in_hit;
    logic               do_unlink;
    logic               do_append;
    logic [IW-1:0]      ul_frame;

    assign in_stall    = (state_reg != ST_IDLE) || out_busy;
    assign accept      = in_valid && !in_stall;
    assign in_frame_ok = 32'(frame) < 32'(NUM_FRAMES);
    assign in_hit      = in_frame_ok && member_reg[MIW'(frame)];
    assign raddr       = (op_t'(func) == OP_VICTIM) ? oldest_reg : IW'(frame);

    always_comb
    begin
        do_unlink = 1'b0;
        do_append = 1'b0;
        ul_frame  = frm_reg;
        case (op_reg)
            OP_VICTIM:
            begin
                do_unlink = (count_reg != '0);
                ul_frame  = oldest_reg;
            end
            OP_PIN:
            begin
                do_unlink = hit_reg;
            end
            OP_UNPIN:
            begin
                do_append = frm_ok_reg && !hit_reg;
            end
            default:
            begin
                do_unlink = 1'b0;
                do_append = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        oldest_next = oldest_reg;
        newest_next = newest_reg;
        count_next  = count_reg;
        member_next = member_reg;
        next_we     = 1'b0;
        next_waddr  = prev_rdata;
        next_wdata  = next_rdata;
        prev_we     = 1'b0;
        prev_waddr  = next_rdata;
        prev_wdata  = prev_rdata;
        res_load    = 1'b0;
        res         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                res_load   = 1'b1;
                if (do_unlink)
                begin
                    if (ul_frame == oldest_reg)
                    begin
                        oldest_next = next_rdata;
                    end
                    else
                    begin
                        next_we = 1'b1;
                    end
                    if (ul_frame == newest_reg)
                    begin
                        newest_next = prev_rdata;
                    end
                    else
                    begin
                        prev_we = 1'b1;
                    end
                    member_next[MIW'(ul_frame)] = 1'b0;
                    count_next = COUNT_W'(count_reg - 1'b1);
                    if (count_next == '0)
                    begin
                        oldest_next = '0;
                        newest_next = '0;
                    end
                end
                else if (do_append)
                begin
                    if (count_reg == '0)
                    begin
                        oldest_next = frm_reg;
                    end
                    else
                    begin
                        next_we    = 1'b1;
                        next_waddr = newest_reg;
                        next_wdata = frm_reg;
                        prev_we    = 1'b1;
                        prev_waddr = frm_reg;
                        prev_wdata = newest_reg;
                    end
                    newest_next = frm_reg;
                    member_next[MIW'(frm_reg)] = 1'b1;
                    count_next = COUNT_W'(count_reg + 1'b1);
                end
                res.found = do_unlink || do_append;
                res.count = count_next;
                if (op_reg == OP_VICTIM && do_unlink)
                begin
                    res.victim_frame = FRAME_W'(oldest_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            oldest_reg <= '0;
            newest_reg <= '0;
            count_reg  <= '0;
            member_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            oldest_reg <= oldest_next;
            newest_reg <= newest_next;
            count_reg  <= count_next;
            member_reg <= member_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op_t'(func);
            frm_reg    <= IW'(frame);
            frm_ok_reg <= in_frame_ok;
            hit_reg    <= in_hit;
        end
    end

endmodule

// ===== src/lru_replacement_tracker_top.sv =====
// ----------------------------------------------------------------------------
// lru_replacement_tracker_top
// Ordered set of evictable frames with victim, pin and unpin requests.
// ----------------------------------------------------------------------------
// The cycle in which a request is accepted starts the read of both link RAMs
// (next/prev), and the following cycle splices the list, writes the links back
// and loads the result register. No new request is accepted until that is done,
// nor while a result still waits downstream. The link RAMs need no clearing
// after reset; requests are taken from the first cycle. Only frames below
// NUM_FRAMES are tracked.
module lru_replacement_tracker_top
    import lrt_pkg::*;
#(
    parameter int NUM_FRAMES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [FRAME_W-1:0] frame,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [FRAME_W-1:0] victim_frame,
    output logic               found,
    output logic [COUNT_W-1:0] count
);

    localparam int IW = $clog2(NUM_FRAMES);

    logic [IW-1:0] raddr;
    logic [IW-1:0] next_rdata, prev_rdata;
    logic          next_we, prev_we;
    logic [IW-1:0] next_waddr, next_wdata;
    logic [IW-1:0] prev_waddr, prev_wdata;
    logic          res_load;
    res_t          res;
    logic          out_busy;

    logic          out_valid_reg, out_valid_next;
    res_t          res_reg;

    lrt_link_ram #(
        .WIDTH (IW),
        .DEPTH (NUM_FRAMES)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (raddr),
        .rdata (next_rdata)
    );

    lrt_link_ram #(
        .WIDTH (IW),
        .DEPTH (NUM_FRAMES)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (raddr),
        .rdata (prev_rdata)
    );

    lrt_list_ctrl #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .frame      (frame),
        .out_busy   (out_busy),
        .raddr      (raddr),
        .next_rdata (next_rdata),
        .prev_rdata (prev_rdata),
        .next_we    (next_we),
        .next_waddr (next_waddr),
        .next_wdata (next_wdata),
        .prev_we    (prev_we),
        .prev_waddr (prev_waddr),
        .prev_wdata (prev_wdata),
        .res_load   (res_load),
        .res        (res)
    );

    // hold off new requests while a result still waits downstream
    assign out_busy = out_valid_reg && out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign victim_frame = res_reg.victim_frame;
    assign found        = res_reg.found;
    assign count        = res_reg.count;

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("request accepted while result stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> ##1 out_valid)
        else $error("no result two cycles after request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(count) <= 32'(NUM_FRAMES)))
        else $error("set size above frame count");

    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (victim_frame == '0))
        else $error("victim frame set on failed request");

endmodule

// ===== dv/lru_tracker_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_tracker_checker
// Watches both channels of the LRU replacement tracker, keeps its own copy of
// the eviction order, and compares every result with the predicted one.
// ----------------------------------------------------------------------------
module lru_tracker_checker
    import lrt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         func,
    input  logic [FRAME_W-1:0] frame,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [FRAME_W-1:0] victim_frame,
    input  logic               found,
    input  logic [COUNT_W-1:0] count,
    output int                 fail_count,
    output int                 pending,
    output int                 checked,
    output int                 peak_count,
    output int                 empty_victims
);

    localparam int NUM_FRAMES = 64;
    localparam int RING_DEPTH = 8;
    localparam int RING_IW    = 3;

    // shadow of the eviction order: doubly linked list, oldest first
    logic [FRAME_W-1:0] newer_of [NUM_FRAMES];
    logic [FRAME_W-1:0] older_of [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] in_set;
    logic [FRAME_W-1:0] head_frame;
    logic [FRAME_W-1:0] tail_frame;
    logic [COUNT_W-1:0] set_size;

    // predicted results waiting for the block's output, oldest at take_cnt
    res_t exp_ring [RING_DEPTH];
    int   put_cnt;
    int   take_cnt;

    initial
    begin
        fail_count    = 0;
        checked       = 0;
        peak_count    = 0;
        empty_victims = 0;
        put_cnt       = 0;
        take_cnt      = 0;
        in_set        = '0;
        head_frame    = '0;
        tail_frame    = '0;
        set_size      = '0;
        newer_of      = '{default: '0};
        older_of      = '{default: '0};
        exp_ring      = '{default: '0};
    end

    assign pending = put_cnt - take_cnt;

    function automatic void remove_from_order(logic [FRAME_W-1:0] f);
        logic [FRAME_W-1:0] older;
        logic [FRAME_W-1:0] newer;
        older = older_of[f];
        newer = newer_of[f];
        if (f == head_frame)
            head_frame = newer;
        else
            newer_of[older] = newer;
        if (f == tail_frame)
            tail_frame = older;
        else
            older_of[newer] = older;
        in_set[f] = 1'b0;
        set_size  = set_size - 1'b1;
        if (set_size == 0)
        begin
            head_frame = '0;
            tail_frame = '0;
        end
    endfunction

    function automatic res_t predict_request(logic [1:0] f, logic [FRAME_W-1:0] fr);
        res_t r;
        r = '0;
        case (f)
            OP_VICTIM:
            begin
                if (set_size != 0)
                begin
                    r.victim_frame = head_frame;
                    r.found        = 1'b1;
                    remove_from_order(head_frame);
                end
                else
                    empty_victims++;
            end
            OP_PIN:
            begin
                if (in_set[fr])
                begin
                    remove_from_order(fr);
                    r.found = 1'b1;
                end
            end
            OP_UNPIN:
            begin
                if (!in_set[fr])
                begin
                    if (set_size == 0)
                        head_frame = fr;
                    else
                    begin
                        newer_of[tail_frame] = fr;
                        older_of[fr]         = tail_frame;
                    end
                    tail_frame = fr;
                    in_set[fr] = 1'b1;
                    set_size   = set_size + 1'b1;
                    r.found    = 1'b1;
                end
            end
            default: ;  // unused code: no effect
        endcase
        r.count = set_size;
        if (int'(set_size) > peak_count)
            peak_count = int'(set_size);
        return r;
    endfunction

    // Sampling mid-cycle: inputs change only at the rising edge, so what is
    // seen here is exactly what the next edge will take.
    always @(negedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (put_cnt - take_cnt >= RING_DEPTH)
                begin
                    $error("more than %0d requests outstanding", RING_DEPTH);
                    fail_count++;
                end
                else
                begin
                    exp_ring[RING_IW'(put_cnt)] = predict_request(func, frame);
                    put_cnt++;
                end
            end
            if (out_valid && !out_stall)
            begin
                checked++;
                if (put_cnt == take_cnt)
                begin
                    $error("result with no request outstanding: %s %0d %0d %0d",
                           "victim_frame/found/count", victim_frame, found, count);
                    fail_count++;
                end
                else
                begin
                    want = exp_ring[RING_IW'(take_cnt)];
                    take_cnt++;
                    if (victim_frame !== want.victim_frame)
                    begin
                        $error("victim_frame: expected %0d, got %0d",
                               want.victim_frame, victim_frame);
                        fail_count++;
                    end
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, found);
                        fail_count++;
                    end
                    if (count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, count);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== dv/tb_lru_replacement_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_replacement_tracker_top
// Drives victim, pin and unpin requests into the LRU replacement tracker:
// a directed opening, then random fill/drain/mixed traffic under four
// handshake pressure phases. Checking is done by lru_tracker_checker.
// ----------------------------------------------------------------------------
module tb_lru_replacement_tracker_top;
    import lrt_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int         RANDOM_REQS = 1030;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         MODE_FILL   = 0;
    localparam int         MODE_DRAIN  = 1;
    localparam int         MODE_MIX    = 2;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         func = OP_VICTIM;
    logic [FRAME_W-1:0] frame = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [FRAME_W-1:0] victim_frame;
    logic               found;
    logic [COUNT_W-1:0] count;

    int fail_count;
    int pending;
    int checked;
    int peak_count;
    int empty_victims;

    int idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;
    int sent = 0;
    int directed = 0;

    logic [FRAME_W-1:0] recent_unpins [8];
    logic [2:0]         recent_ptr = '0;

    always #5 clk = ~clk;

    lru_replacement_tracker_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .frame        (frame),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .victim_frame (victim_frame),
        .found        (found),
        .count        (count)
    );

    lru_tracker_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .frame         (frame),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .victim_frame  (victim_frame),
        .found         (found),
        .count         (count),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked),
        .peak_count    (peak_count),
        .empty_victims (empty_victims)
    );

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Called right after a rising edge; returns right after the edge that
    // took the request. Stall is looked at mid-cycle to stay clear of the edge.
    task automatic send_request(input logic [1:0] f, input logic [FRAME_W-1:0] fr);
        logic stalled;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        frame    <= fr;
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
        if (f == OP_UNPIN)
        begin
            recent_unpins[recent_ptr] = fr;
            recent_ptr = recent_ptr + 3'd1;
        end
        sent++;
    endtask

    initial
    begin
        int                 mode;
        int                 r;
        int                 fill_ptr;
        logic [1:0]         op;
        logic [FRAME_W-1:0] fr;

        fill_ptr = 0;
        recent_unpins = '{default: '0};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening, no idling
        send_request(OP_VICTIM, 6'd63);       // empty set
        send_request(OP_PIN, 6'd0);           // pin of a non-member
        send_request(OP_UNPIN, 6'd0);
        send_request(OP_UNPIN, 6'd63);
        send_request(OP_UNPIN, 6'd0);         // already present: no refresh
        send_request(OP_UNPIN, 6'd21);
        send_request(OP_UNPIN, 6'd42);
        send_request(OP_PIN, 6'd63);          // removal from the middle
        send_request(OP_PIN, 6'd0);           // removal of the oldest
        send_request(OP_PIN, 6'd42);          // removal of the newest
        send_request(OP_RESERVED, 6'd63);
        send_request(OP_VICTIM, 6'd0);        // last member
        send_request(OP_VICTIM, 6'd42);
        send_request(OP_UNPIN, 6'd42);
        send_request(OP_UNPIN, 6'd21);
        send_request(OP_VICTIM, 6'd21);
        send_request(OP_PIN, 6'd21);          // sole member
        send_request(OP_RESERVED, 6'd0);
        send_request(OP_PIN, 6'd21);
        send_request(OP_UNPIN, 6'd63);
        send_request(OP_RESERVED, 6'd42);     // unused code with a non-empty set
        send_request(OP_VICTIM, 6'd0);
        directed = sent;

        mode = MODE_FILL;
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            case (n / (RANDOM_REQS / 4))
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 64; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            if (n % 40 == 0)
            begin
                mode = $urandom_range(2);
                fill_ptr = $urandom_range(63);
            end
            r = $urandom_range(99);
            case (mode)
                MODE_FILL:
                    op = (r < 75) ? OP_UNPIN : (r < 85) ? OP_PIN :
                         (r < 96) ? OP_VICTIM : OP_RESERVED;
                MODE_DRAIN:
                    op = (r < 45) ? OP_VICTIM : (r < 80) ? OP_PIN :
                         (r < 97) ? OP_UNPIN : OP_RESERVED;
                default:
                    op = (r < 33) ? OP_VICTIM : (r < 63) ? OP_PIN :
                         (r < 95) ? OP_UNPIN : OP_RESERVED;
            endcase
            fr = FRAME_W'($urandom_range(63));
            // sequential unpins fill the set quickly; pins favor recent members
            if (op == OP_UNPIN && mode == MODE_FILL && $urandom_range(1) == 1)
            begin
                fr = fill_ptr[FRAME_W-1:0];
                fill_ptr = (fill_ptr + 1) % 64;
            end
            else if (op == OP_PIN && $urandom_range(9) < 6)
                fr = recent_unpins[3'($urandom_range(7))];
            send_request(op, fr);
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d requests sent (%0d directed), %0d results checked over four pressure phases",
                 sent, directed, checked);
        $display("peak occupancy %0d of 64 frames, %0d victim requests on an empty set",
                 peak_count, empty_victims);
        if (fail_count == 0 && checked == sent)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
